// ===== hdl/utf8ssd_pkg.sv =====
// Shared types, status codes and lead-byte tables for the six-byte UTF-8 decoder.
package utf8ssd_pkg;

  localparam int unsigned CP_W  = 31;
  localparam int unsigned CNT_W = 3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ST_BAD_CONT  = 3'd2;
  localparam logic [2:0] ST_OVERLONG  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  localparam logic [CNT_W-1:0] MAX_LEN = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [2:0]       status;
    logic [CNT_W-1:0] seq_bytes;
    logic [CNT_W-1:0] error_position;
  } out_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  partial_value;
    logic [CNT_W-1:0] bytes_pending;
    logic [CNT_W-1:0] sequence_length;
  } dec_state_t;

  // Sequence length announced by a lead byte; 0 marks an invalid lead.
  function automatic logic [CNT_W-1:0] lead_length(input logic [7:0] b);
    logic [CNT_W-1:0] n;
    if (b < 8'h80)      n = 3'd1;
    else if (b < 8'hC0) n = 3'd0;
    else if (b < 8'hE0) n = 3'd2;
    else if (b < 8'hF0) n = 3'd3;
    else if (b < 8'hF8) n = 3'd4;
    else if (b < 8'hFC) n = 3'd5;
    else if (b < 8'hFE) n = 3'd6;
    else                n = 3'd0;
    return n;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [CNT_W-1:0] n);
    logic [7:0] m;
    case (n)
      3'd1:    m = 8'h7F;
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Smallest code point that a sequence of length n may carry.
  function automatic logic [CP_W-1:0] min_value(input logic [CNT_W-1:0] n);
    logic [CP_W-1:0] v;
    case (n)
      3'd2:    v = 31'h80;
      3'd3:    v = 31'h800;
      3'd4:    v = 31'h10000;
      3'd5:    v = 31'h200000;
      3'd6:    v = 31'h4000000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/utf8_six_byte_stream_decoder.sv =====
// Top level of the six-byte UTF-8 stream decoder: input register, decode, result register.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   stream   | stream_valid/stream_ready  | stream_item: data_byte, stream_end
//   cp       | cp_valid/cp_ready          | cp_item: code_point, status, seq_bytes,
//            |                            |          error_position
//
// One byte per clock sustained while cp_ready keeps up: an accepted item sits in the
// input register, is decoded against the sequence state in a single pass as it advances
// and, if it makes a result, lands in the result register, from which it is offered.
// Synchronous reset clears the sequence state and both valid flags.
// A stalled result holds the decode stage and every later item, whether or not it
// makes a result; the input register still takes one more item.
module utf8_six_byte_stream_decoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   stream_valid,
  output logic                   stream_ready,
  input  utf8ssd_pkg::in_item_t  stream_item,
  output logic                   cp_valid,
  input  logic                   cp_ready,
  output utf8ssd_pkg::out_item_t cp_item
);

  utf8ssd_pkg::in_item_t   in_reg;
  logic                    in_full;
  utf8ssd_pkg::dec_state_t state;
  utf8ssd_pkg::dec_state_t state_next;
  logic                    has_result;
  utf8ssd_pkg::out_item_t  result;
  logic                    advance;

  utf8ssd_step u_step (
    .state      (state),
    .item       (in_reg),
    .state_next (state_next),
    .has_result (has_result),
    .result     (result)
  );

  assign advance      = in_full && (!cp_valid || cp_ready);
  assign stream_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      cp_valid <= 1'b0;
      state    <= '0;
    end else begin
      if (stream_valid && stream_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        state    <= state_next;
        cp_valid <= has_result;
      end else if (cp_ready) begin
        cp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream_valid && stream_ready) begin
      in_reg <= stream_item;
    end
    if (advance && has_result) begin
      cp_item <= result;
    end
  end

endmodule

// ===== hdl/utf8ssd_step.sv =====
// Combinational decode of one item against the current sequence state.
module utf8ssd_step (
  input  utf8ssd_pkg::dec_state_t state,
  input  utf8ssd_pkg::in_item_t   item,
  output utf8ssd_pkg::dec_state_t state_next,
  output logic                    has_result,
  output utf8ssd_pkg::out_item_t  result
);

  logic [utf8ssd_pkg::CNT_W-1:0] n_lead;
  logic [utf8ssd_pkg::CNT_W-1:0] n_cur;
  logic [utf8ssd_pkg::CNT_W-1:0] pend_dec;
  logic [utf8ssd_pkg::CP_W-1:0]  shifted;

  always_comb begin
    n_lead   = utf8ssd_pkg::lead_length(item.data_byte);
    n_cur    = (state.sequence_length > utf8ssd_pkg::MAX_LEN) ?
               utf8ssd_pkg::MAX_LEN : state.sequence_length;
    pend_dec = state.bytes_pending - 3'd1;
    shifted  = {state.partial_value[utf8ssd_pkg::CP_W-7:0], item.data_byte[5:0]};

    state_next = state;
    has_result = 1'b0;
    result     = '0;

    if (item.stream_end) begin
      if (state.bytes_pending != '0) begin
        has_result            = 1'b1;
        result.status         = utf8ssd_pkg::ST_TRUNCATED;
        result.seq_bytes      = state.sequence_length;
        result.error_position = state.sequence_length - state.bytes_pending;
        state_next            = '0;
      end
    end else if (state.bytes_pending == '0) begin
      if (n_lead == 3'd0) begin
        has_result       = 1'b1;
        result.status    = utf8ssd_pkg::ST_BAD_LEAD;
        result.seq_bytes = 3'd1;
      end else if (n_lead == 3'd1) begin
        has_result        = 1'b1;
        result.status     = utf8ssd_pkg::ST_OK;
        result.seq_bytes  = 3'd1;
        result.code_point = {23'd0, item.data_byte};
      end else begin
        state_next.partial_value   = {23'd0, item.data_byte & utf8ssd_pkg::lead_mask(n_lead)};
        state_next.sequence_length = n_lead;
        state_next.bytes_pending   = n_lead - 3'd1;
      end
    end else if (item.data_byte[7:6] != 2'b10) begin
      // not a continuation byte: drop it, do not reuse as a lead
      has_result            = 1'b1;
      result.status         = utf8ssd_pkg::ST_BAD_CONT;
      result.seq_bytes      = n_cur;
      result.error_position = n_cur - state.bytes_pending;
      state_next            = '0;
    end else if (pend_dec != '0) begin
      state_next.partial_value = shifted;
      state_next.bytes_pending = pend_dec;
    end else begin
      has_result       = 1'b1;
      result.seq_bytes = n_cur;
      state_next       = '0;
      if (shifted < utf8ssd_pkg::min_value(n_cur)) begin
        result.status         = utf8ssd_pkg::ST_OVERLONG;
        result.error_position = n_cur - 3'd1;
      end else begin
        result.status     = utf8ssd_pkg::ST_OK;
        result.code_point = shifted;
      end
    end
  end

endmodule

// ===== tb/tb_utf8_six_byte_stream_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the six-byte UTF-8 stream decoder, with a built-in decode model.
module tb_utf8_six_byte_stream_decoder;

  localparam int N_ITEMS     = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_EVERY = 500;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_DUTY} rx_mode_t;

  typedef struct {
    bit                    drain;  // marker: hold the sender until all results are back
    utf8ssd_pkg::in_item_t item;
  } stim_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   stream_valid = 1'b0;
  logic                   stream_ready;
  utf8ssd_pkg::in_item_t  stream_item = '0;
  logic                   cp_valid;
  logic                   cp_ready = 1'b0;
  utf8ssd_pkg::out_item_t cp_item;

  stim_t                  byte_q[$];
  utf8ssd_pkg::out_item_t cp_expected[$];
  int                     mismatches = 0;
  int                     n_items = 0;
  bit                     byte_taken = 1'b0;

  // decoder model state
  logic [utf8ssd_pkg::CP_W-1:0]  dec_acc = '0;
  logic [utf8ssd_pkg::CNT_W-1:0] dec_left = '0;
  logic [utf8ssd_pkg::CNT_W-1:0] dec_len = '0;

  utf8_six_byte_stream_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_item  (stream_item),
    .cp_valid     (cp_valid),
    .cp_ready     (cp_ready),
    .cp_item      (cp_item)
  );

  always #5 clk = ~clk;

  // Payload bits carried by a lead byte of an n-byte sequence.
  function automatic logic [7:0] lead_bits(input int n);
    return (n == 1) ? 8'h7F : (8'hFF >> (n + 1));
  endfunction

  // Two-byte forms start at bit 7, longer ones at bit 5n-4.
  function automatic longint seq_min(input int n);
    if (n < 2) return 0;
    if (n == 2) return 'h80;
    return longint'(1) << (5 * n - 4);
  endfunction

  function automatic longint seq_max(input int n);
    return (n < 2) ? 'h7F : ((longint'(1) << (5 * n + 1)) - 1);
  endfunction

  // Returns 1 and fills res when the item completes or breaks a sequence.
  function automatic bit decode_item(input utf8ssd_pkg::in_item_t it,
                                     output utf8ssd_pkg::out_item_t res);
    logic [7:0]                    b;
    logic [utf8ssd_pkg::CNT_W-1:0] n;
    logic [utf8ssd_pkg::CP_W-1:0]  v;
    b   = it.data_byte;
    res = '0;
    if (it.stream_end) begin
      if (dec_left == 0) return 1'b0;
      res.status         = utf8ssd_pkg::ST_TRUNCATED;
      res.seq_bytes      = dec_len;
      res.error_position = dec_len - dec_left;
      dec_acc = '0; dec_left = '0; dec_len = '0;
      return 1'b1;
    end
    if (dec_left == 0) begin
      casez (b)
        8'b0???????: n = 3'd1;
        8'b110?????: n = 3'd2;
        8'b1110????: n = 3'd3;
        8'b11110???: n = 3'd4;
        8'b111110??: n = 3'd5;
        8'b1111110?: n = 3'd6;
        default:     n = 3'd0;
      endcase
      if (n == 0) begin
        res.status    = utf8ssd_pkg::ST_BAD_LEAD;
        res.seq_bytes = 3'd1;
        return 1'b1;
      end
      if (n == 1) begin
        res.code_point = utf8ssd_pkg::CP_W'(b);
        res.status     = utf8ssd_pkg::ST_OK;
        res.seq_bytes  = 3'd1;
        return 1'b1;
      end
      dec_acc  = utf8ssd_pkg::CP_W'(b & lead_bits(n));
      dec_len  = n;
      dec_left = n - 3'd1;
      return 1'b0;
    end
    if (b[7:6] != 2'b10) begin
      // offending byte is dropped, never reused as a lead
      res.status         = utf8ssd_pkg::ST_BAD_CONT;
      res.seq_bytes      = dec_len;
      res.error_position = dec_len - dec_left;
      dec_acc = '0; dec_left = '0; dec_len = '0;
      return 1'b1;
    end
    dec_acc  = {dec_acc[utf8ssd_pkg::CP_W-7:0], b[5:0]};
    dec_left = dec_left - 3'd1;
    if (dec_left != 0) return 1'b0;
    v = dec_acc;
    res.seq_bytes = dec_len;
    if (longint'(v) < seq_min(dec_len)) begin
      res.status         = utf8ssd_pkg::ST_OVERLONG;
      res.error_position = dec_len - 3'd1;
    end else begin
      res.code_point = v;
      res.status     = utf8ssd_pkg::ST_OK;
    end
    dec_acc = '0; dec_left = '0; dec_len = '0;
    return 1'b1;
  endfunction

  // Byte k of the n-byte encoding of cp (k = 0 is the lead).
  function automatic logic [7:0] seq_byte(input int n, input logic [utf8ssd_pkg::CP_W-1:0] cp,
                                          input int k);
    logic [7:0] prefix;
    case (n)
      2:       prefix = 8'hC0;
      3:       prefix = 8'hE0;
      4:       prefix = 8'hF0;
      5:       prefix = 8'hF8;
      6:       prefix = 8'hFC;
      default: prefix = 8'h00;
    endcase
    if (k == 0) return prefix | (8'(cp >> (6 * (n - 1))) & lead_bits(n));
    return 8'h80 | (8'(cp >> (6 * (n - 1 - k))) & 8'h3F);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic e);
    stim_t s;
    s.drain = 1'b0;
    s.item.data_byte  = b;
    s.item.stream_end = e;
    byte_q.push_back(s);
    n_items++;
  endtask

  task automatic push_seq(input int n, input logic [utf8ssd_pkg::CP_W-1:0] cp);
    for (int k = 0; k < n; k++) push_byte(seq_byte(n, cp, k), 1'b0);
  endtask

  task automatic push_drain();
    stim_t s;
    s.drain = 1'b1;
    s.item  = '0;
    byte_q.push_back(s);
  endtask

  function automatic logic [utf8ssd_pkg::CP_W-1:0] pick_cp(input longint lo, input longint hi);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return utf8ssd_pkg::CP_W'(lo);
    if (sel == 1) return utf8ssd_pkg::CP_W'(hi);
    return utf8ssd_pkg::CP_W'(lo + (longint'($urandom) % (hi - lo + 1)));
  endfunction

  // A byte of either non-continuation form: 00..7F or C0..FF.
  function automatic logic [7:0] not_cont();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b[7:6] == 2'b10) b = $urandom_range(0, 1) ? (b ^ 8'h80) : (b | 8'h40);
    return b;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : sender
    bit                    nv;
    utf8ssd_pkg::in_item_t ni;
    nv = 1'b0;
    ni = stream_item;
    if (!rst) begin
      if (stream_valid && !byte_taken) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (byte_q.size() > 0) begin
        if (byte_q[0].drain) begin
          if (cp_expected.size() == 0) void'(byte_q.pop_front());
        end else begin
          ni = byte_q.pop_front().item;
          nv = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
    stream_valid <= nv;
    stream_item  <= ni;
  end

  // receiver: stall pattern switches between modes after runs of random length
  rx_mode_t rx_mode = RX_OPEN;
  int rx_run = 0;
  int rx_tick = 0;

  always @(negedge clk) begin
    if (rx_run == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_run  = $urandom_range(10, 80);
    end else begin
      rx_run--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  cp_ready <= 1'b1;
      RX_COIN:  cp_ready <= 1'($urandom_range(0, 1));
      RX_CHOKE: cp_ready <= ($urandom_range(0, 7) == 0);
      default:  cp_ready <= ((rx_tick % 5) < 2);
    endcase
  end

  utf8ssd_pkg::out_item_t cp_want;
  utf8ssd_pkg::out_item_t cp_new;

  always @(posedge clk) begin
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      if (cp_valid && cp_ready) begin
        if (cp_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: cp=%h st=%0d len=%0d pos=%0d", cp_item.code_point,
                     cp_item.status, cp_item.seq_bytes, cp_item.error_position);
        end else begin
          cp_want = cp_expected.pop_front();
          if (cp_item.code_point !== cp_want.code_point || cp_item.status !== cp_want.status ||
              cp_item.seq_bytes !== cp_want.seq_bytes ||
              cp_item.error_position !== cp_want.error_position) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: exp cp=%h st=%0d len=%0d pos=%0d, ",
                        "got cp=%h st=%0d len=%0d pos=%0d"},
                       cp_want.code_point, cp_want.status, cp_want.seq_bytes,
                       cp_want.error_position, cp_item.code_point, cp_item.status,
                       cp_item.seq_bytes, cp_item.error_position);
          end
        end
      end
      byte_taken = stream_valid && stream_ready;
      if (byte_taken && decode_item(stream_item, cp_new)) cp_expected.push_back(cp_new);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int     pick;
    int     n;
    int     k;
    int     next_drain;
    stim_t  s;
    logic [utf8ssd_pkg::CP_W-1:0] cp;

    // directed: edges of the byte ranges and every error kind
    s.drain = 1'b0;
    s.item.data_byte  = 8'hA5;
    s.item.stream_end = 1'b1;
    byte_q.push_back(s);                  // end marker while idle
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);               // 0x80 is not a lead
    push_byte(8'hFE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_seq(2, 31'h80);                  // smallest two-byte value
    push_byte(8'hC0, 1'b0);               // overlong two-byte zero
    push_byte(8'h80, 1'b0);
    push_byte(8'hE0, 1'b0);               // cut off by end marker
    push_byte(8'h00, 1'b1);
    push_seq(6, 31'h7FFFFFFF);            // largest code point
    push_byte(8'hF0, 1'b0);               // bad continuation, byte dropped
    push_byte(8'h41, 1'b0);
    push_seq(3, 31'hD800);                // surrogate decodes normally
    push_drain();

    next_drain = n_items + DRAIN_EVERY;
    while (n_items < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      n    = $urandom_range(1, 6);
      if (pick < 60) begin
        push_seq(n, pick_cp(seq_min(n), seq_max(n)));
      end else if (pick < 68) begin
        n = $urandom_range(2, 6);
        push_seq(n, pick_cp(0, seq_min(n) - 1));
      end else if (pick < 76) begin
        n  = $urandom_range(2, 6);
        cp = pick_cp(seq_min(n), seq_max(n));
        k  = $urandom_range(1, n - 1);
        for (int i = 0; i < k; i++) push_byte(seq_byte(n, cp, i), 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 84) begin
        n  = $urandom_range(2, 6);
        cp = pick_cp(seq_min(n), seq_max(n));
        k  = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) push_byte((i == k) ? not_cont() : seq_byte(n, cp, i), 1'b0);
      end else if (pick < 93) begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        s.drain = 1'b0;
        s.item.data_byte  = 8'($urandom_range(0, 255));
        s.item.stream_end = 1'b1;
        byte_q.push_back(s);
      end
      if (n_items >= next_drain) begin
        push_drain();
        next_drain = n_items + DRAIN_EVERY;
      end
    end

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    while (byte_q.size() > 0 || stream_valid) @(negedge clk);
    while (cp_expected.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && cp_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
